### rtl/nist_pkg.sv
// nist_pkg: shared types and codes for the neighbor interval statistics table
// no dependencies
`default_nettype none
package nist_pkg;
	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_ADDED    = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [15:0] GAP_MAX = 16'hFFFF;
	localparam logic [7:0] WEIGHT_RESET = 8'd51;
	localparam logic [7:0] THRESH_RESET = 8'd3;

	localparam logic [1:0] REG_WEIGHT = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;

	typedef struct packed {
		logic        action;
		logic [15:0] addr;
		logic [31:0] seqno;
		logic [39:0] asn;
		logic        routing_child;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        paired;
		logic [4:0]  child_total;
		logic        unpaired_child;
		logic [4:0]  neighbor_count;
		logic [23:0] gap_mean;
		logic [39:0] gap_variance;
	} out_word_t;

	// multiply-accumulate request to the shared unit
	typedef struct packed {
		logic        start;
		logic [47:0] a;
		logic [7:0]  b;
		logic [55:0] acc;
	} mac_req_t;

	typedef struct packed {
		logic        done;
		logic [55:0] sum;
	} mac_rsp_t;
endpackage
`default_nettype wire

### rtl/nist_if.sv
// nist_if: valid/ready channel carrying one word of a given type
// no dependencies; the payload type is a parameter
`default_nettype none
interface nist_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/nist_mac.sv
// nist_mac: shared multiply-accumulate, 48x8 product built 8 bits per cycle
// depends on nist_pkg
`default_nettype none
module nist_mac (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nist_pkg::mac_req_t  req,
	output nist_pkg::mac_rsp_t       rsp
);
	logic [2:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [47:0] a_q;
	logic [7:0]  b_q;
	logic [55:0] acc_q;
	logic [15:0] part;

	// one 8x8 partial product a cycle
	assign part = a_q[7:0] * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= req.acc;
		end else if (busy_q) begin
			acc_q <= acc_q + (56'(part) << (6'(step_q) * 6'd8));
			a_q <= a_q >> 8;
		end
	end
	assign rsp = {done_q, acc_q};
endmodule
`default_nettype wire

### rtl/neighbor_interval_stats_table_core.sv
// neighbor_interval_stats_table_core: neighbor table with ewma gap statistics
// depends on nist_pkg, nist_if and nist_mac
//
// channel  dir  payload
// in_ch    in   action, addr, seqno, asn, routing_child
// out_ch   out  status, paired, counts, gap_mean, gap_variance
// apb      in   ewma_weight at 0x0, pair_threshold at 0x4
//
// one entry per cycle for the lookup and again for the child statistics; a word
// runs through the lookup and the decision, then for a refresh a write-back,
// preceded, when the gap statistics run, by six passes through the shared
// multiply-accumulate, then the child statistics and the output register; a new
// word is accepted only after the result is taken
// reset clears the state, valid bits, the live count and the apb registers; table contents are not cleared
// the output register holds until taken
`default_nettype none
module neighbor_interval_stats_table_core #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDRESS_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	nist_if.sink             in_ch,
	nist_if.source           out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = (ADDRESS_WIDTH < 16) ? ADDRESS_WIDTH : 16;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_SCAN  = 12'b000000000010,
		S_DEC   = 12'b000000000100,
		S_M1    = 12'b000000001000,
		S_M2    = 12'b000000010000,
		S_Q1    = 12'b000000100000,
		S_Q2    = 12'b000001000000,
		S_V1    = 12'b000010000000,
		S_V2    = 12'b000100000000,
		S_WB    = 12'b001000000000,
		S_STAT  = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [7:0] weight_q, thresh_q;

	// apb
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= nist_pkg::WEIGHT_RESET;
			thresh_q <= nist_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				nist_pkg::REG_WEIGHT[0]: weight_q <= pwdata[7:0];
				default: thresh_q <= pwdata[7:0];
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			nist_pkg::REG_WEIGHT[0]: prdata = {24'd0, weight_q};
			default: prdata = {24'd0, thresh_q};
		endcase
	end

	// table
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [AW-1:0]  addr_mem [TABLE_ENTRIES];
	logic [31:0]    first_mem [TABLE_ENTRIES];
	logic [31:0]    last_mem [TABLE_ENTRIES];
	logic           child_mem [TABLE_ENTRIES];
	logic [39:0]    slot_mem [TABLE_ENTRIES];
	logic [23:0]    mean_mem [TABLE_ENTRIES];
	logic [39:0]    var_mem [TABLE_ENTRIES];
	logic [CW-1:0]  live_q;

	nist_pkg::in_word_t  in_q;
	nist_pkg::out_word_t out_q;
	logic [IW:0] idx_q;
	logic [IW-1:0] hit_q, free_q;
	logic hit_ok_q, free_ok_q;
	logic [IW-1:0] ent;
	assign ent = idx_q[IW-1:0];

	// working copy of the touched entry
	logic [31:0] first_q, last_q;
	logic [39:0] slot_q;
	logic [23:0] mean_q;
	logic [39:0] var_q;
	logic [CW-1:0] kids_q;
	logic unp_q;

	logic [39:0] gap_full;
	logic [15:0] gap;
	logic do_stat, do_mac;

	// gap to the stored slot, saturated; slot_q stays put until the next lookup
	assign gap_full = in_q.asn - slot_q;
	assign gap = (gap_full > 40'(nist_pkg::GAP_MAX)) ? nist_pkg::GAP_MAX : gap_full[15:0];
	assign do_stat = (slot_q != '0) && (in_q.asn > slot_q) && hit_ok_q;
	// a zero mean is seeded directly, otherwise the ewma runs on the shared unit
	assign do_mac = do_stat && (mean_q != '0);

	nist_pkg::mac_req_t req;
	nist_pkg::mac_rsp_t rsp;
	nist_mac u_mac (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	logic [7:0] wc;
	logic wz;
	assign wc = 8'(9'd256 - {1'b0, weight_q});
	// a zero weight keeps the old value: 256*x is fed as (x << 8) * 1
	assign wz = (weight_q == 8'd0);
	logic [15:0] mi;
	logic [15:0] ad;
	always_comb begin
		// new mean straight from the accumulator while it is written back
		mi = (state_q == S_M2) ? rsp.sum[31:16] : mean_q[23:8];
		ad = (gap >= mi) ? gap - mi : mi - gap;
	end

	logic [31:0] adv;
	assign adv = last_mem[ent] - first_mem[ent];

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data = out_q;

	nist_pkg::out_word_t dec_word;
	always_comb begin
		dec_word = '0;
		if (in_q.action == nist_pkg::ACT_REMOVE) begin
			dec_word.status = hit_ok_q ? nist_pkg::ST_REMOVED : nist_pkg::ST_NOTFOUND;
		end else if (hit_ok_q) begin
			dec_word.status = nist_pkg::ST_UPDATED;
		end else if (free_ok_q) begin
			// a fresh entry has advanced by zero
			dec_word.status = nist_pkg::ST_ADDED;
			dec_word.paired = (thresh_q == 8'd0);
		end else begin
			dec_word.status = nist_pkg::ST_FULL;
		end
	end

	always_comb begin
		req = '0;
		case (state_q)
			S_DEC: begin
				req.start = do_mac;
				req.a = {24'd0, gap, 8'd0};
				req.b = weight_q;
				req.acc = 56'd128;
			end
			S_M1: begin
				req.start = rsp.done;
				req.a = wz ? {16'd0, mean_q, 8'd0} : {24'd0, mean_q};
				req.b = wz ? 8'd1 : wc;
				req.acc = rsp.sum;
			end
			// square of the deviation, low byte then high byte
			S_M2: begin
				req.start = rsp.done;
				req.a = {32'd0, ad};
				req.b = ad[7:0];
				req.acc = 56'd0;
			end
			S_Q1: begin
				req.start = rsp.done;
				req.a = {24'd0, ad, 8'd0};
				req.b = ad[15:8];
				req.acc = rsp.sum;
			end
			S_Q2: begin
				req.start = rsp.done;
				req.a = {8'd0, rsp.sum[31:0], 8'd0};
				req.b = weight_q;
				req.acc = 56'd128;
			end
			S_V1: begin
				req.start = rsp.done;
				req.a = wz ? {var_q, 8'd0} : {8'd0, var_q};
				req.b = wz ? 8'd1 : wc;
				req.acc = rsp.sum;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			live_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid) state_q <= S_SCAN;
				S_SCAN: if (idx_q == (IW+1)'(TABLE_ENTRIES - 1)) state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_STAT;
					if (in_q.action == nist_pkg::ACT_REMOVE) begin
						if (hit_ok_q) begin
							valid_q[hit_q] <= 1'b0;
							if (live_q != '0) live_q <= live_q - CW'(1);
						end
					end else if (hit_ok_q) begin
						state_q <= do_mac ? S_M1 : S_WB;
					end else if (free_ok_q) begin
						valid_q[free_q] <= 1'b1;
						live_q <= live_q + CW'(1);
					end
				end
				S_M1: if (rsp.done) state_q <= S_M2;
				S_M2: if (rsp.done) state_q <= S_Q1;
				S_Q1: if (rsp.done) state_q <= S_Q2;
				S_Q2: if (rsp.done) state_q <= S_V1;
				S_V1: if (rsp.done) state_q <= S_V2;
				S_V2: if (rsp.done) state_q <= S_WB;
				S_WB: state_q <= S_STAT;
				S_STAT: if (idx_q == (IW+1)'(TABLE_ENTRIES - 1)) state_q <= S_OUT;
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_q <= in_ch.data;
				idx_q <= '0;
				hit_ok_q <= 1'b0;
				free_ok_q <= 1'b0;
			end
			S_SCAN: begin
				if (valid_q[ent] && addr_mem[ent] == in_q.addr[AW-1:0] && !hit_ok_q) begin
					hit_ok_q <= 1'b1;
					hit_q <= ent;
					first_q <= first_mem[ent];
					last_q <= last_mem[ent];
					slot_q <= slot_mem[ent];
					mean_q <= mean_mem[ent];
					var_q <= var_mem[ent];
				end
				if (!valid_q[ent] && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q <= ent;
				end
				idx_q <= idx_q + (IW+1)'(1);
			end
			S_DEC: begin
				idx_q <= '0;
				kids_q <= '0;
				unp_q <= 1'b0;
				out_q <= dec_word;
				if (in_q.action == nist_pkg::ACT_UPDATE) begin
					if (hit_ok_q) begin
						if (in_q.seqno > last_q) last_q <= in_q.seqno;
						if (do_stat && mean_q == '0) begin
							mean_q <= {gap, 8'd0};
							var_q <= '0;
						end
					end else if (free_ok_q) begin
						addr_mem[free_q] <= in_q.addr[AW-1:0];
						first_mem[free_q] <= in_q.seqno;
						last_mem[free_q] <= in_q.seqno;
						child_mem[free_q] <= in_q.routing_child;
						slot_mem[free_q] <= in_q.asn;
						mean_mem[free_q] <= '0;
						var_mem[free_q] <= '0;
					end
				end
			end
			S_M2: if (rsp.done) mean_q <= 24'(rsp.sum >> 8);
			S_V2: if (rsp.done) var_q <= 40'(rsp.sum >> 8);
			S_WB: begin
				last_mem[hit_q] <= last_q;
				slot_mem[hit_q] <= in_q.asn;
				mean_mem[hit_q] <= mean_q;
				var_mem[hit_q] <= var_q;
				out_q.status <= nist_pkg::ST_UPDATED;
				out_q.paired <= ((last_q - first_q) >= {24'd0, thresh_q});
				out_q.gap_mean <= mean_q;
				out_q.gap_variance <= var_q;
			end
			S_STAT: begin
				if (valid_q[ent] && child_mem[ent]) begin
					kids_q <= kids_q + CW'(1);
					if (adv < {24'd0, thresh_q}) unp_q <= 1'b1;
				end
				idx_q <= idx_q + (IW+1)'(1);
				if (idx_q == (IW+1)'(TABLE_ENTRIES - 1)) begin
					out_q.child_total <= (kids_q + CW'(valid_q[ent] && child_mem[ent])) > CW'(31)
						? 5'd31 : 5'(kids_q + CW'(valid_q[ent] && child_mem[ent]));
					out_q.unpaired_child <= unp_q ||
						(valid_q[ent] && child_mem[ent] && adv < {24'd0, thresh_q});
					out_q.neighbor_count <= (live_q > CW'(31)) ? 5'd31 : 5'(live_q);
				end
			end
			default: ;
		endcase
	end

	check_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while stalled");
	check_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input taken while result pending");
	check_live: assert property (@(posedge clk) disable iff (!arst_n)
		live_q == CW'($countones(valid_q)))
		else $error("live count disagrees with valid bits");
endmodule
`default_nettype wire
